>>> design/dosp_pkg.sv
// Shared types and constants for the DHCP option stream parser.
package dosp_pkg;

    // Field widths fixed by the packet format
    localparam int POS_W  = 11;
    localparam int BYTE_W = 8;

    // Option area layout and special codes
    localparam logic [POS_W-1:0]  OPT_START_M1  = 11'd239;
    localparam logic [BYTE_W-1:0] CODE_PAD      = 8'd0;
    localparam logic [BYTE_W-1:0] CODE_END      = 8'd255;
    localparam logic [BYTE_W-1:0] CODE_MSG_TYPE = 8'd53;
    localparam logic [BYTE_W-1:0] OP_BOOTREQ    = 8'd1;

    // Configuration register indexes and reset values
    localparam logic CFG_MIN_LEN = 1'b0;
    localparam logic CFG_VENDOR  = 1'b1;
    localparam logic [POS_W-1:0]  MIN_LEN_RST = 11'd272;
    localparam logic [BYTE_W-1:0] VENDOR_RST  = 8'd43;

    // Queue between parser and record output
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_CODE   = 3'd1,
        PH_LEN    = 3'd2,
        PH_DATA   = 3'd3,
        PH_DONE   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        SP_IDLE = 2'd0,
        SP_CODE = 2'd1,
        SP_LEN  = 2'd2,
        SP_DATA = 2'd3
    } t_sub;

    typedef enum logic [1:0] {
        KIND_OPTION  = 2'd0,
        KIND_SUB     = 2'd1,
        KIND_VERDICT = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        VERD_ACCEPT    = 2'd0,
        VERD_SHORT     = 2'd1,
        VERD_NOT_REQ   = 2'd2,
        VERD_NO_MSGTYP = 2'd3
    } t_verdict;

    // Work produced by one byte: at most one option record and one verdict
    typedef struct packed {
        logic              has_rec;
        t_kind             rec_kind;
        logic [BYTE_W-1:0] rec_code;
        logic [BYTE_W-1:0] rec_len;
        logic [POS_W-1:0]  rec_off;
        logic              has_verdict;
        t_verdict          verdict;
    } t_entry;

endpackage

>>> design/dhcp_option_stream_parser.sv
// DHCP/BOOTP option stream parser top level.
// A byte's result items are written into the queue when the byte is taken.
// Throughput: one byte per cycle while the queue is not full; a byte that closes
// an option or sub-option header and the packet gives two items, popped in turn from a four-entry queue.
// Reset (synchronous, active low) clears the parse state and the queue and
// loads the registers with min length 272 and vendor option code 43.
module dhcp_option_stream_parser
    import dosp_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = 2048
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    output logic              empty,
    input  logic              pop,
    output logic [1:0]        o_record_kind,
    output logic [7:0]        o_option_code,
    output logic [7:0]        o_option_length,
    output logic [10:0]       o_data_offset,
    output logic [1:0]        o_verdict,
    output logic              o_last_result,
    input  logic              i_cfg_we,
    input  logic              i_cfg_addr,
    input  logic [10:0]       i_cfg_wdata
);

    localparam int               LIMIT_INT = (MAX_PACKET_BYTES > 2048) ? 2047
                                                                       : MAX_PACKET_BYTES - 1;
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(LIMIT_INT);

    logic [POS_W-1:0]  r_min_len;
    logic [BYTE_W-1:0] r_vendor;
    logic              accept;
    logic              q_push;
    logic              q_pop;
    logic              q_empty;
    t_entry            q_wdata;
    t_entry            q_head;

    assign accept = push && !full;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= MIN_LEN_RST;
            r_vendor  <= VENDOR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MIN_LEN: r_min_len <= i_cfg_wdata;
                CFG_VENDOR:  r_vendor  <= i_cfg_wdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    dosp_front #(
        .POS_LIMIT (POS_LIMIT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .i_min_len     (r_min_len),
        .i_vendor_code (r_vendor),
        .o_push        (q_push),
        .o_entry       (q_wdata)
    );

    dosp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_push),
        .i_wdata (q_wdata),
        .i_rd    (q_pop),
        .o_rdata (q_head),
        .o_empty (q_empty),
        .o_full  (full)
    );

    dosp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_entry         (q_head),
        .i_q_empty       (q_empty),
        .o_q_pop         (q_pop),
        .i_pop           (pop),
        .o_empty         (empty),
        .o_record_kind   (o_record_kind),
        .o_option_code   (o_option_code),
        .o_option_length (o_option_length),
        .o_data_offset   (o_data_offset),
        .o_verdict       (o_verdict),
        .o_last_result   (o_last_result)
    );

    // A verdict always closes the items of its byte
    a_verdict_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_record_kind == KIND_VERDICT |-> o_last_result)
        else $error("verdict item without last_result");

    // A record taken without last_result is followed by its verdict
    a_verdict_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !empty && !o_last_result |=> !empty && o_record_kind == KIND_VERDICT)
        else $error("record not followed by verdict");

    // A full queue always has something to deliver
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !empty)
        else $error("queue full and empty at once");

    // Queue entry only when a byte is taken
    a_push_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> accept)
        else $error("queue written without an accepted item");

endmodule

>>> design/dosp_front.sv
// Byte parser: walks header, options and vendor sub-options, builds queue entries.
module dosp_front
    import dosp_pkg::*;
#(
    parameter logic [POS_W-1:0] POS_LIMIT = 11'd2047
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_last_byte,
    input  logic [POS_W-1:0]  i_min_len,
    input  logic [BYTE_W-1:0] i_vendor_code,
    output logic              o_push,
    output t_entry            o_entry
);

    logic [POS_W-1:0]  r_pos,      n_pos;
    t_phase            r_phase,    n_phase;
    logic [BYTE_W-1:0] r_code,     n_code;
    logic [BYTE_W-1:0] r_remain,   n_remain;
    logic [BYTE_W-1:0] r_op,       n_op;
    logic              r_msg,      n_msg;
    t_sub              r_sub,      n_sub;
    logic [BYTE_W-1:0] r_sub_code, n_sub_code;
    logic [BYTE_W-1:0] r_sub_rem,  n_sub_rem;

    logic [POS_W-1:0]  next_off;
    logic [BYTE_W-1:0] sub_rem_dec;
    logic [BYTE_W-1:0] remain_dec;
    logic [POS_W:0]    pkt_len;
    t_entry            entry;

    assign next_off    = (r_pos >= POS_LIMIT) ? POS_LIMIT : r_pos + 11'd1;
    assign sub_rem_dec = r_sub_rem - 8'd1;
    assign remain_dec  = r_remain - 8'd1;
    assign pkt_len     = {1'b0, r_pos} + 12'd1;

    // Hold state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_phase    <= PH_HEADER;
            r_code     <= '0;
            r_remain   <= '0;
            r_op       <= '0;
            r_msg      <= 1'b0;
            r_sub      <= SP_IDLE;
            r_sub_code <= '0;
            r_sub_rem  <= '0;
        end else if (i_accept) begin
            r_pos      <= n_pos;
            r_phase    <= n_phase;
            r_code     <= n_code;
            r_remain   <= n_remain;
            r_op       <= n_op;
            r_msg      <= n_msg;
            r_sub      <= n_sub;
            r_sub_code <= n_sub_code;
            r_sub_rem  <= n_sub_rem;
        end
    end

    // Parse one byte and build its entry
    always_comb begin
        n_pos      = r_pos;
        n_phase    = r_phase;
        n_code     = r_code;
        n_remain   = r_remain;
        n_op       = r_op;
        n_msg      = r_msg;
        n_sub      = r_sub;
        n_sub_code = r_sub_code;
        n_sub_rem  = r_sub_rem;

        entry             = '0;
        entry.rec_kind    = KIND_OPTION;
        entry.verdict     = VERD_ACCEPT;

        case (r_phase)
            PH_HEADER: begin
                if (r_pos == '0) n_op = i_data_byte;
                if (r_pos >= OPT_START_M1) n_phase = PH_CODE;
            end
            PH_CODE: begin
                if (i_data_byte == CODE_END) begin
                    n_phase = PH_DONE;
                end else if (i_data_byte != CODE_PAD) begin
                    n_code  = i_data_byte;
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                entry.has_rec  = 1'b1;
                entry.rec_kind = KIND_OPTION;
                entry.rec_code = r_code;
                entry.rec_len  = i_data_byte;
                entry.rec_off  = next_off;
                if (r_code == CODE_MSG_TYPE) n_msg = (i_data_byte != 8'd0);
                n_remain = i_data_byte;
                if (i_data_byte == 8'd0) begin
                    n_phase = PH_CODE;
                    n_sub   = SP_IDLE;
                end else begin
                    n_phase = PH_DATA;
                    n_sub   = (r_code == i_vendor_code) ? SP_CODE : SP_IDLE;
                end
            end
            PH_DATA: begin
                // Walk vendor sub-options inside the option data
                case (r_sub)
                    SP_CODE: begin
                        if (i_data_byte == CODE_END) begin
                            n_sub = SP_IDLE;
                        end else if (i_data_byte != CODE_PAD) begin
                            n_sub_code = i_data_byte;
                            n_sub      = SP_LEN;
                        end
                    end
                    SP_LEN: begin
                        entry.has_rec  = 1'b1;
                        entry.rec_kind = KIND_SUB;
                        entry.rec_code = r_sub_code;
                        entry.rec_len  = i_data_byte;
                        entry.rec_off  = next_off;
                        n_sub_rem      = i_data_byte;
                        n_sub          = (i_data_byte == 8'd0) ? SP_CODE : SP_DATA;
                    end
                    SP_DATA: begin
                        n_sub_rem = sub_rem_dec;
                        if (sub_rem_dec == 8'd0) n_sub = SP_CODE;
                    end
                    default: ;
                endcase
                n_remain = remain_dec;
                if (remain_dec == 8'd0) begin
                    n_phase = PH_CODE;
                    n_sub   = SP_IDLE;
                end
            end
            default: ;
        endcase

        // Advance position or stop parsing at the limit
        if (r_pos >= POS_LIMIT) n_phase = PH_DONE;
        else                    n_pos   = r_pos + 11'd1;

        // Close the packet: verdict and clear
        if (i_last_byte) begin
            entry.has_verdict = 1'b1;
            if (pkt_len < {1'b0, i_min_len})  entry.verdict = VERD_SHORT;
            else if (n_op != OP_BOOTREQ)      entry.verdict = VERD_NOT_REQ;
            else if (!n_msg)                  entry.verdict = VERD_NO_MSGTYP;
            else                              entry.verdict = VERD_ACCEPT;
            n_pos      = '0;
            n_phase    = PH_HEADER;
            n_code     = '0;
            n_remain   = '0;
            n_op       = '0;
            n_msg      = 1'b0;
            n_sub      = SP_IDLE;
            n_sub_code = '0;
            n_sub_rem  = '0;
        end
    end

    assign o_entry = entry;
    assign o_push  = i_accept && (entry.has_rec || entry.has_verdict);

endmodule

>>> design/dosp_queue.sv
// Short entry queue between the parser and the record output.
module dosp_queue
    import dosp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr,
    input  t_entry i_wdata,
    input  logic   i_rd,
    output t_entry o_rdata,
    output logic   o_empty,
    output logic   o_full
);

    t_entry             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count, n_count;
    logic               wr_ok;
    logic               rd_ok;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (wr_ok && !rd_ok)      n_count = r_count + 1'b1;
        else if (rd_ok && !wr_ok) n_count = r_count - 1'b1;
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (wr_ok) r_mem[r_wr_ptr] <= i_wdata;
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_ok) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (rd_ok) r_rd_ptr <= r_rd_ptr + 1'b1;
            r_count <= n_count;
        end
    end

endmodule

>>> design/dosp_back.sv
// Record output: splits each queue entry into one or two result items.
module dosp_back
    import dosp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_entry            i_entry,
    input  logic              i_q_empty,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [1:0]        o_record_kind,
    output logic [BYTE_W-1:0] o_option_code,
    output logic [BYTE_W-1:0] o_option_length,
    output logic [POS_W-1:0]  o_data_offset,
    output logic [1:0]        o_verdict,
    output logic              o_last_result
);

    logic r_second;
    logic show_rec;
    logic take;

    assign show_rec = i_entry.has_rec && !r_second;
    assign take     = i_pop && !i_q_empty;
    assign o_empty  = i_q_empty;
    assign o_q_pop  = take && !(show_rec && i_entry.has_verdict);

    // Select the record or the verdict of the head entry
    always_comb begin
        if (show_rec) begin
            o_record_kind   = i_entry.rec_kind;
            o_option_code   = i_entry.rec_code;
            o_option_length = i_entry.rec_len;
            o_data_offset   = i_entry.rec_off;
            o_verdict       = VERD_ACCEPT;
            o_last_result   = !i_entry.has_verdict;
        end else begin
            o_record_kind   = KIND_VERDICT;
            o_option_code   = '0;
            o_option_length = '0;
            o_data_offset   = '0;
            o_verdict       = i_entry.verdict;
            o_last_result   = 1'b1;
        end
    end

    // Track whether the option record of the head entry is already taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second <= 1'b0;
        end else if (take) begin
            r_second <= show_rec && i_entry.has_verdict;
        end
    end

endmodule
